FILE: hdl/mpi_pkg.sv
// mpi_pkg: shared types, constants and helpers for the mass point integrator
// no dependencies
package mpi_pkg;

   localparam int DIV_BITS      = 48;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;
   localparam int TAIL_STAGES   = 7;
   localparam int NUM_STAGES    = 1 + DIV_STAGES + TAIL_STAGES;

   localparam logic signed [63:0] GRAVITY_Q = 64'sd642253;

   localparam logic [0:0] CSR_TIME_STEP = 1'd0;
   localparam logic [0:0] CSR_DAMPING   = 1'd1;

   localparam logic [16:0] TIME_STEP_RESET = 17'd655;
   localparam logic [30:0] DAMPING_RESET   = 31'd65536;

   // per-item control fields that travel down the whole pipe
   typedef struct packed {
      logic [2:0][31:0] vel;
      logic [2:0][31:0] pos;
      logic [2:0][47:0] damp;
      logic [2:0]       neg;
      logic [2:0]       fzero;
      logic [30:0]      mass;
      logic             movable;
      logic             grav;
   } item_type;

   // one restoring divider lane
   typedef struct packed {
      logic [47:0] dvd;
      logic [47:0] quo;
      logic [31:0] rem;
   } div_type;

   typedef div_type [2:0] div_lanes_type;

   // datapath after the divider
   typedef struct packed {
      logic [2:0][31:0] acc;
      logic [2:0][49:0] prod_a;
      logic [2:0][33:0] tstep;
      logic [2:0][31:0] nvel;
      logic [2:0][49:0] prod_v;
      logic [2:0][51:0] prod_t;
      logic [2:0][31:0] npos;
   } tail_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/mass_point_integrator.sv
// mass_point_integrator: pipelined euler step for one mass point per transfer
// depends on mpi_pkg
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | force, velocity, position, mass, flags
//  rsp     | out       | rsp_valid/rsp_stall | new acceleration, velocity, position
//  csr     | in        | csr_write           | csr_index, csr_wdata
//
// one transfer per cycle unless a result waits on a stalled receiver
// the pipe depth is set by the 48-bit force/mass divider, 4 quotient bits per stage
// reset (synchronous, active high) clears the stage valid bits and loads the csr defaults
// a stalled result holds the whole pipe; bubbles keep moving only with it
module mass_point_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_force_x,
   input  logic [31:0] req_force_y,
   input  logic [31:0] req_force_z,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   input  logic [31:0] req_vel_z,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [30:0] req_point_mass,
   input  logic        req_is_movable,
   input  logic        req_use_gravity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_new_accel_x,
   output logic [31:0] rsp_new_accel_y,
   output logic [31:0] rsp_new_accel_z,
   output logic [31:0] rsp_new_vel_x,
   output logic [31:0] rsp_new_vel_y,
   output logic [31:0] rsp_new_vel_z,
   output logic [31:0] rsp_new_pos_x,
   output logic [31:0] rsp_new_pos_y,
   output logic [31:0] rsp_new_pos_z,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import mpi_pkg::*;

   localparam int LAST = NUM_STAGES - 1;
   localparam int T0   = DIV_STAGES + 1;   // first stage after the divider

   // configuration
   logic [16:0] time_step_ff;
   logic [30:0] damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= TIME_STEP_RESET;
         damping_ff   <= DAMPING_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TIME_STEP: time_step_ff <= csr_wdata[16:0];
            CSR_DAMPING:   damping_ff   <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // global advance: the pipe moves unless a result waits on a stalled receiver
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic          val_ff  [NUM_STAGES];
   item_type      ctl_ff  [NUM_STAGES];
   div_lanes_type div_ff  [DIV_STAGES + 1];
   div_lanes_type div_in  [DIV_STAGES + 1];
   tail_type      tail_ff [T0:LAST];
   tail_type      tail_in [T0:LAST];
   item_type      ctl_in0;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            val_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         val_ff[0] <= req_valid;
         for (int s = 1; s < NUM_STAGES; s++) begin
            val_ff[s] <= val_ff[s - 1];
         end
      end
   end

   // input stage: force magnitude to dividend, damping product per axis
   always_comb begin
      logic [2:0][31:0] f;
      logic [31:0]      fmag;
      logic signed [63:0] dprod;
      f = {req_force_z, req_force_y, req_force_x};
      ctl_in0.vel     = {req_vel_z, req_vel_y, req_vel_x};
      ctl_in0.pos     = {req_pos_z, req_pos_y, req_pos_x};
      ctl_in0.mass    = req_point_mass;
      ctl_in0.movable = req_is_movable;
      ctl_in0.grav    = req_use_gravity;
      for (int k = 0; k < 3; k++) begin
         ctl_in0.neg[k]   = f[k][31];
         ctl_in0.fzero[k] = (f[k] == 32'd0);
         fmag = f[k][31] ? (32'd0 - f[k]) : f[k];
         div_in[0][k].dvd = {fmag, 16'd0};
         div_in[0][k].quo = '0;
         div_in[0][k].rem = '0;
         // floor(vel * damp / 2^16) fits 48 bits
         dprod = $signed(ctl_in0.vel[k]) * $signed({1'b0, damping_ff});
         ctl_in0.damp[k] = 48'(dprod >>> 16);
      end
   end

   // restoring divider stages, four quotient bits each
   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      always_comb begin
         logic [31:0] sh_rem;
         div_in[s] = div_ff[s - 1];
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
               sh_rem = {div_in[s][k].rem[30:0], div_in[s][k].dvd[DIV_BITS - 1]};
               div_in[s][k].dvd = div_in[s][k].dvd << 1;
               if (sh_rem >= {1'b0, ctl_ff[s - 1].mass}) begin
                  div_in[s][k].rem = sh_rem - {1'b0, ctl_ff[s - 1].mass};
                  div_in[s][k].quo = {div_in[s][k].quo[DIV_BITS - 2:0], 1'b1};
               end else begin
                  div_in[s][k].rem = sh_rem;
                  div_in[s][k].quo = {div_in[s][k].quo[DIV_BITS - 2:0], 1'b0};
               end
            end
         end
      end
   end

   // tail stages
   always_comb begin
      logic [47:0]        q;
      logic signed [48:0] ad;
      logic signed [48:0] aa;
      logic signed [48:0] av;
      logic signed [63:0] wide;
      logic signed [49:0] pa;
      logic signed [51:0] pt;
      logic signed [49:0] pv;

      // sign and saturate the quotient; zero force gives zero even for zero mass
      tail_in[T0] = '0;
      for (int k = 0; k < 3; k++) begin
         q = div_ff[DIV_STAGES][k].quo;
         if (ctl_ff[DIV_STAGES].fzero[k]) begin
            tail_in[T0].acc[k] = '0;
         end else if (ctl_ff[DIV_STAGES].neg[k]) begin
            tail_in[T0].acc[k] = (q > 48'h0000_8000_0000) ? 32'h8000_0000
                                                          : (32'd0 - q[31:0]);
         end else begin
            tail_in[T0].acc[k] = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
         end
      end

      // damping applies only when its magnitude is below the acceleration's
      tail_in[T0 + 1] = tail_ff[T0];
      for (int k = 0; k < 3; k++) begin
         ad = 49'($signed(ctl_ff[T0].damp[k]));
         aa = 49'($signed(tail_ff[T0].acc[k]));
         av = aa[48] ? -aa : aa;
         if ((ad[48] ? -ad : ad) < av) begin
            wide = 64'(aa - ad);
            tail_in[T0 + 1].acc[k] = sat32(wide);
         end
      end

      // gravity on y
      tail_in[T0 + 2] = tail_ff[T0 + 1];
      if (ctl_ff[T0 + 1].grav) begin
         wide = 64'($signed(tail_ff[T0 + 1].acc[1])) - GRAVITY_Q;
         tail_in[T0 + 2].acc[1] = sat32(wide);
      end

      // a * dt
      tail_in[T0 + 3] = tail_ff[T0 + 2];
      for (int k = 0; k < 3; k++) begin
         pa = $signed(tail_ff[T0 + 2].acc[k]) * $signed({1'b0, time_step_ff});
         tail_in[T0 + 3].prod_a[k] = pa;
      end

      // t and the new velocity
      tail_in[T0 + 4] = tail_ff[T0 + 3];
      for (int k = 0; k < 3; k++) begin
         pa = $signed(tail_ff[T0 + 3].prod_a[k]);
         tail_in[T0 + 4].tstep[k] = 34'(pa >>> 16);
         wide = 64'($signed(ctl_ff[T0 + 3].vel[k])) + 64'(pa >>> 16);
         tail_in[T0 + 4].nvel[k] = sat32(wide);
      end

      // v' * dt and t * dt
      tail_in[T0 + 5] = tail_ff[T0 + 4];
      for (int k = 0; k < 3; k++) begin
         pv = $signed(tail_ff[T0 + 4].nvel[k]) * $signed({1'b0, time_step_ff});
         pt = $signed(tail_ff[T0 + 4].tstep[k]) * $signed({1'b0, time_step_ff});
         tail_in[T0 + 5].prod_v[k] = pv;
         tail_in[T0 + 5].prod_t[k] = pt;
      end

      // new position, pinned points pass through
      tail_in[LAST] = tail_ff[T0 + 5];
      for (int k = 0; k < 3; k++) begin
         pv = $signed(tail_ff[T0 + 5].prod_v[k]);
         pt = $signed(tail_ff[T0 + 5].prod_t[k]);
         wide = 64'($signed(ctl_ff[T0 + 5].pos[k])) + 64'(pv >>> 16) + 64'(pt >>> 17);
         if (ctl_ff[T0 + 5].movable) begin
            tail_in[LAST].npos[k] = sat32(wide);
         end else begin
            tail_in[LAST].acc[k]  = '0;
            tail_in[LAST].nvel[k] = ctl_ff[T0 + 5].vel[k];
            tail_in[LAST].npos[k] = ctl_ff[T0 + 5].pos[k];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         ctl_ff[0] <= ctl_in0;
         for (int s = 1; s < NUM_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s - 1];
         end
         for (int s = 0; s <= DIV_STAGES; s++) begin
            div_ff[s] <= div_in[s];
         end
         for (int s = T0; s <= LAST; s++) begin
            tail_ff[s] <= tail_in[s];
         end
      end
   end

   assign rsp_valid       = val_ff[LAST];
   assign rsp_new_accel_x = tail_ff[LAST].acc[0];
   assign rsp_new_accel_y = tail_ff[LAST].acc[1];
   assign rsp_new_accel_z = tail_ff[LAST].acc[2];
   assign rsp_new_vel_x   = tail_ff[LAST].nvel[0];
   assign rsp_new_vel_y   = tail_ff[LAST].nvel[1];
   assign rsp_new_vel_z   = tail_ff[LAST].nvel[2];
   assign rsp_new_pos_x   = tail_ff[LAST].npos[0];
   assign rsp_new_pos_y   = tail_ff[LAST].npos[1];
   assign rsp_new_pos_z   = tail_ff[LAST].npos[2];

`ifndef NO_ASSERTIONS
   // the input side only waits behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // a pinned point never reports acceleration
   a_pinned_accel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !ctl_ff[LAST].movable) |->
         (rsp_new_accel_x == 32'd0 && rsp_new_accel_y == 32'd0 &&
          rsp_new_accel_z == 32'd0))
      else $error("pinned point with nonzero acceleration");

   // an accepted transfer enters the divider on the next advance
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> val_ff[0])
      else $error("accepted transfer lost at pipe entry");
`endif

endmodule
